[rtl/touch_panel_event_decoder_core_defines.svh]
// Assertion macros shared by the touch panel event decoder RTL
`ifndef TOUCH_PANEL_EVENT_DECODER_CORE_DEFINES_SVH
`define TOUCH_PANEL_EVENT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define TPED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tped assertion failed");
// Condition must never be true outside reset
`define TPED_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("tped forbidden condition seen");
`else
`define TPED_ASSERT(lbl, clk, rstn, prop)
`define TPED_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/tped_pkg.sv]
// Shared types, constants and the pad action table of the touch panel event decoder
package tped_pkg;

  // Defaults for the top level parameters
  localparam int BOARD_COUNT_DEF     = 3;
  localparam int ELECTRODE_COUNT_DEF = 12;

  // Internal electrode mask width (largest supported electrode count)
  localparam int EMAX        = 16;
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [15:0] LONG_PRESS_RST  = 16'd800;
  localparam logic [7:0]  BRIGHT_HIGH_RST = 8'd240;
  localparam logic [7:0]  BRIGHT_LOW_RST  = 8'd15;

  // Register indexes
  localparam logic [1:0] CFG_LONG_PRESS  = 2'd0;
  localparam logic [1:0] CFG_BRIGHT_HIGH = 2'd1;
  localparam logic [1:0] CFG_BRIGHT_LOW  = 2'd2;

  // Action codes
  localparam logic [3:0] ACT_TOGGLE = 4'd10;
  localparam logic [3:0] ACT_DIM    = 4'd11;
  localparam logic [3:0] ACT_CHAND  = 4'd14;
  localparam logic [3:0] ACT_NONE   = 4'd15;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [7:0]  bright_high;
    logic [7:0]  bright_low;
  } cfg_t;

  // One sample's worth of work for the back end
  typedef struct packed {
    logic [1:0]      board;
    logic [EMAX-1:0] emit_mask;   // electrodes that produce a result
    logic            chand_dim;   // chandelier result is a dim (else toggle)
    logic            dim_up;
  } entry_t;

  // Per-board pad actions; 14 marks a chandelier pad, 15 an unused pad
  localparam logic [3:0] PAD_TABLE [8][16] = '{
    '{4'd4, 4'd8, 4'd14, 4'd15, 4'd15, 4'd9, 4'd2, 4'd15,
      4'd15, 4'd0, 4'd1, 4'd3, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd8, 4'd9, 4'd7, 4'd6, 4'd15, 4'd15, 4'd5, 4'd15,
      4'd15, 4'd12, 4'd14, 4'd12, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd8, 4'd9, 4'd6, 4'd7, 4'd15, 4'd15, 4'd5, 4'd15,
      4'd15, 4'd12, 4'd12, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15},
    '{default: 4'd15},
    '{default: 4'd15},
    '{default: 4'd15},
    '{default: 4'd15},
    '{default: 4'd15}
  };

  function automatic logic [3:0] pad_action(input logic [2:0] b, input logic [3:0] e);
    return PAD_TABLE[b][e];
  endfunction

endpackage

[rtl/touch_panel_event_decoder_core.sv]
// Top level of the touch panel event decoder: configuration registers and unit wiring
//
// Input channel (in_*): one touch sample per transfer, board number, 12-bit
// electrode mask, 32-bit millisecond time and current brightness. Samples
// from a board beyond the board count are dropped without effect.
// Result channel (out_*): one action per transfer, in ascending electrode
// order; out_last marks the final action of a sample. Samples that cause no
// action produce no transfer.
// Configuration (cfg_*): one register write per cycle with cfg_we high.
// Timing: a sample is taken every cycle while the four-entry entry queue
// has room. The back end emits one action per cycle while out_stall is low,
// so a sample with k actions (1 to 8) holds it until all k are out. The first
// action of a sample passes the front stage A and B registers, the queue,
// the back end entry register and the output register before it is valid.
// Reset (synchronous, rst_n low): stored masks cleared, chandelier timer
// idle, registers back to 800 ms, 240 and 15.
// When out_stall is high a valid output register holds; the queue and front
// stages fill and then in_stall rises.

module touch_panel_event_decoder_core import tped_pkg::*; #(
  parameter int BOARD_COUNT     = BOARD_COUNT_DEF,
  parameter int ELECTRODE_COUNT = ELECTRODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_board,
  input  logic [11:0] in_touch_mask,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_action,
  output logic        out_dim_up,
  output logic        out_last
);

  cfg_t   cfg_r;
  logic   q_push, q_pop, q_full, q_nempty;
  entry_t q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.bright_high   <= BRIGHT_HIGH_RST;
      cfg_r.bright_low    <= BRIGHT_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS:  cfg_r.long_press_ms <= cfg_wdata;
        CFG_BRIGHT_HIGH: cfg_r.bright_high   <= cfg_wdata[7:0];
        CFG_BRIGHT_LOW:  cfg_r.bright_low    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  tped_front #(
    .BOARD_COUNT     (BOARD_COUNT),
    .ELECTRODE_COUNT (ELECTRODE_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_board      (in_board),
    .in_touch_mask (in_touch_mask),
    .in_now_ms     (in_now_ms),
    .in_brightness (in_brightness),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  tped_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .full   (q_full),
    .nempty (q_nempty)
  );

  tped_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nempty   (q_nempty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_action (out_action),
    .out_dim_up (out_dim_up),
    .out_last   (out_last)
  );

endmodule

[rtl/tped_queue.sv]
// Small FIFO of decoded sample entries between the front and back ends
`include "touch_panel_event_decoder_core_defines.svh"

module tped_queue import tped_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   nempty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  entry_t        slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r, count_nxt;

  assign full   = (count_r == (AW+1)'(QUEUE_DEPTH));
  assign nempty = (count_r != '0);
  assign rdata  = slot_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

  `TPED_ASSERT(a_q_count_range, clk, rst_n, count_r <= (AW+1)'(QUEUE_DEPTH))
  `TPED_NEVER(a_q_pop_empty, clk, rst_n, pop && !nempty)

endmodule

[rtl/tped_front.sv]
// Front end: accepts samples, finds changed pads, runs the chandelier press timer
`include "touch_panel_event_decoder_core_defines.svh"

module tped_front import tped_pkg::*; #(
  parameter int BOARD_COUNT     = BOARD_COUNT_DEF,
  parameter int ELECTRODE_COUNT = ELECTRODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_board,
  input  logic [11:0] in_touch_mask,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_brightness,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_data
);

  localparam logic [EMAX-1:0] EMASK = EMAX'((32'd1 << ELECTRODE_COUNT) - 32'd1);
  // d mod 300 = 4 * ((d >> 2) mod 75) + d[1:0]; quotient by 75 via reciprocal
  localparam logic [29:0] MOD_RECIP = 30'd916259689;  // floor(2^36 / 75)
  localparam logic [7:0]  QUARTER   = 8'd75;
  localparam logic [8:0]  DIM_WIN   = 9'd50;

  typedef struct packed {
    logic [1:0]      board;
    logic [EMAX-1:0] ord_mask;   // ordinary pads pressed
    logic [EMAX-1:0] chand_bit;  // changed chandelier pad
    logic            c_emit;     // chandelier result certain
    logic            c_check;    // chandelier dim subject to the 300 ms grid
    logic            c_dim;
    logic            c_up;
    logic [1:0]      d_lo;
    logic [29:0]     x;          // elapsed time >> 2
  } stage_t;

  logic [ELECTRODE_COUNT-1:0] prior_r [BOARD_COUNT];
  logic [31:0] press_start_r, press_start_nxt;
  logic        press_held_r, press_held_nxt;
  logic        long_on_r, long_on_nxt;
  logic        dir_up_r, dir_up_nxt;

  logic            a_valid_r, b_valid_r;
  stage_t          a_r, b_r, a_nxt;
  logic [23:0]     bq_r;
  logic [59:0]     prod;

  logic            board_ok, accept;
  logic [EMAX-1:0] prior16, mask16, changed, chand_tbl, live_tbl, chand_chg;
  logic [3:0]      act_i;
  logic            chand_press, chand_hit;
  logic [31:0]     elapsed;
  logic            b_done, b_ready;
  logic [29:0]     q75, rem;
  logic [7:0]      r8, rc;
  logic [8:0]      m9;
  logic            in_window;
  logic [EMAX-1:0] emit_mask;

  // Handshake: stage A moves on whenever stage B can take it
  assign b_done   = b_valid_r && ((emit_mask == '0) || !q_full);
  assign b_ready  = !b_valid_r || b_done;
  assign in_stall = a_valid_r && !b_ready;
  assign accept   = in_valid && !in_stall;

  // Classify the sample
  always_comb begin
    board_ok = (32'(in_board) < 32'(BOARD_COUNT));
    prior16  = '0;
    for (int b = 0; b < BOARD_COUNT; b++) begin
      if (32'(in_board) == 32'(b)) prior16 = EMAX'(prior_r[b]);
    end
    mask16  = EMAX'(in_touch_mask) & EMASK;
    changed = mask16 ^ prior16;
    act_i   = ACT_NONE;
    for (int i = 0; i < EMAX; i++) begin
      act_i        = pad_action({1'b0, in_board}, 4'(i));
      chand_tbl[i] = (act_i == ACT_CHAND);
      live_tbl[i]  = (act_i != ACT_CHAND) && (act_i != ACT_NONE);
    end
    // each board has at most one chandelier pad
    chand_chg   = changed & chand_tbl;
    chand_hit   = |chand_chg;
    chand_press = |(chand_chg & mask16);
    elapsed     = in_now_ms - press_start_r;
  end

  // Chandelier press timer
  always_comb begin
    press_start_nxt = press_start_r;
    press_held_nxt  = press_held_r;
    long_on_nxt     = long_on_r;
    dir_up_nxt      = dir_up_r;
    a_nxt           = '0;
    a_nxt.board     = in_board;
    a_nxt.ord_mask  = changed & mask16 & live_tbl;
    a_nxt.chand_bit = chand_chg;
    a_nxt.d_lo      = elapsed[1:0];
    a_nxt.x         = elapsed[31:2];
    if (chand_hit) begin
      if (chand_press) begin
        if (!press_held_r) begin
          // first press: start timing, zero elapsed gives no result
          press_start_nxt = in_now_ms;
          press_held_nxt  = 1'b1;
          long_on_nxt     = 1'b0;
        end else if ((elapsed > {16'd0, cfg.long_press_ms}) && !long_on_r) begin
          long_on_nxt = 1'b1;
          if (in_brightness >= cfg.bright_high)     dir_up_nxt = 1'b0;
          else if (in_brightness <= cfg.bright_low) dir_up_nxt = 1'b1;
          a_nxt.c_emit = 1'b1;
          a_nxt.c_dim  = 1'b1;
          a_nxt.c_up   = dir_up_nxt;
        end else if (long_on_r) begin
          a_nxt.c_check = 1'b1;
          a_nxt.c_dim   = 1'b1;
          a_nxt.c_up    = dir_up_r;
        end
      end else if (press_held_r) begin
        // release: short press toggles
        a_nxt.c_emit   = !long_on_r && (elapsed < {16'd0, cfg.long_press_ms});
        press_held_nxt = 1'b0;
        long_on_nxt    = 1'b0;
      end
    end
  end

  // Press state and stored masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BOARD_COUNT; b++) prior_r[b] <= '0;
      press_start_r <= '0;
      press_held_r  <= 1'b0;
      long_on_r     <= 1'b0;
      dir_up_r      <= 1'b0;
    end else if (accept && board_ok) begin
      for (int b = 0; b < BOARD_COUNT; b++) begin
        if (32'(in_board) == 32'(b)) prior_r[b] <= mask16[ELECTRODE_COUNT-1:0];
      end
      press_start_r <= press_start_nxt;
      press_held_r  <= press_held_nxt;
      long_on_r     <= long_on_nxt;
      dir_up_r      <= dir_up_nxt;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        a_valid_r <= accept && board_ok &&
                     ((a_nxt.ord_mask != '0) || a_nxt.c_emit || a_nxt.c_check);
      end
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  // Stage B: quotient of elapsed/4 by 75
  assign prod = 60'(a_r.x) * 60'(MOD_RECIP);

  always_ff @(posedge clk) begin
    if (!in_stall) a_r <= a_nxt;
    if (b_ready) begin
      b_r  <= a_r;
      bq_r <= prod[59:36];
    end
  end

  // Remainder correction and dim grid test
  always_comb begin
    q75       = 30'({bq_r, 6'd0}) + 30'({bq_r, 3'd0}) + 30'({bq_r, 1'b0}) + 30'(bq_r);
    rem       = b_r.x - q75;
    r8        = rem[7:0];
    rc        = (r8 >= QUARTER) ? (r8 - QUARTER) : r8;
    m9        = {rc[6:0], b_r.d_lo};
    in_window = (m9 < DIM_WIN);
    emit_mask = b_r.ord_mask |
                ((b_r.c_emit || (b_r.c_check && in_window)) ? b_r.chand_bit : '0);
  end

  assign q_push           = b_valid_r && (emit_mask != '0) && !q_full;
  assign q_data.board     = b_r.board;
  assign q_data.emit_mask = emit_mask;
  assign q_data.chand_dim = b_r.c_dim;
  assign q_data.dim_up    = b_r.c_up;

  `TPED_NEVER(a_fr_long_without_hold, clk, rst_n, long_on_r && !press_held_r)

endmodule

[rtl/tped_back.sv]
// Back end: walks the result mask of each entry, one action per cycle while the output is not stalled
`include "touch_panel_event_decoder_core_defines.svh"

module tped_back import tped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nempty,
  input  entry_t     q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_action,
  output logic       out_dim_up,
  output logic       out_last
);

  entry_t          cur_r;
  logic            cur_valid_r;
  logic            out_valid_r;
  logic [3:0]      out_action_r;
  logic            out_dim_up_r, out_last_r;

  logic [3:0]      idx, tbl, act;
  logic            up, is_last, out_free, fire;
  logic [EMAX-1:0] rest;

  // Lowest pending electrode and its action
  always_comb begin
    idx = '0;
    for (int i = EMAX - 1; i >= 0; i--) begin
      if (cur_r.emit_mask[i]) idx = 4'(i);
    end
    rest    = cur_r.emit_mask & (cur_r.emit_mask - 1'b1);
    is_last = (rest == '0);
    tbl     = pad_action({1'b0, cur_r.board}, idx);
    if (tbl == ACT_CHAND) begin
      act = cur_r.chand_dim ? ACT_DIM : ACT_TOGGLE;
      up  = cur_r.chand_dim && cur_r.dim_up;
    end else begin
      act = tbl;
      up  = 1'b0;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = cur_valid_r && out_free;
  assign q_pop    = q_nempty && (!cur_valid_r || (fire && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop)               cur_valid_r <= 1'b1;
      else if (fire && is_last) cur_valid_r <= 1'b0;
      if (fire)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Current entry and output register
  always_ff @(posedge clk) begin
    if (q_pop)     cur_r <= q_data;
    else if (fire) cur_r.emit_mask <= rest;
    if (fire) begin
      out_action_r <= act;
      out_dim_up_r <= up;
      out_last_r   <= is_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_dim_up = out_dim_up_r;
  assign out_last   = out_last_r;

  `TPED_ASSERT(a_bk_cur_nonempty, clk, rst_n, cur_valid_r |-> (cur_r.emit_mask != '0))
  `TPED_ASSERT(a_bk_entry_continues, clk, rst_n, (fire && !is_last) |=> cur_valid_r)

endmodule

[bench/tped_checker.sv]
`timescale 1ns / 1ps
// Result checker for the touch panel event decoder: predicts actions per sample and compares
module tped_checker import tped_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_board,
  input  logic [11:0] in_touch_mask,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_brightness,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_action,
  input  logic        out_dim_up,
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding,
  output int          actions_checked,
  output int          dims_checked,
  output int          toggles_checked
);

  // Lamp and blind actions
  localparam logic [3:0] ACT_WINDOW_UP    = 4'd0;
  localparam logic [3:0] ACT_WINDOW_DOWN  = 4'd1;
  localparam logic [3:0] ACT_DOOR_UP      = 4'd2;
  localparam logic [3:0] ACT_DOOR_DOWN    = 4'd3;
  localparam logic [3:0] ACT_GARDEN       = 4'd4;
  localparam logic [3:0] ACT_STONE        = 4'd5;
  localparam logic [3:0] ACT_KITCHEN_WORK = 4'd6;
  localparam logic [3:0] ACT_KITCHEN      = 4'd7;
  localparam logic [3:0] ACT_HALL         = 4'd8;
  localparam logic [3:0] ACT_BEAM         = 4'd9;
  localparam logic [3:0] ACT_ALL          = 4'd12;

  // Repeat-dim grid while a long press is active
  localparam logic [31:0] DIM_PERIOD_MS = 32'd300;
  localparam logic [31:0] DIM_WINDOW_MS = 32'd50;

  localparam int NBOARDS = BOARD_COUNT_DEF;
  localparam int NPADS   = ELECTRODE_COUNT_DEF;

  typedef struct packed {
    logic [3:0] action;
    logic       dim_up;
    logic       last;
  } action_rec_t;

  // Pad assignment per board, electrode 0 first
  localparam logic [3:0] PADS [NBOARDS][NPADS] = '{
    '{ACT_GARDEN, ACT_HALL, ACT_CHAND, ACT_NONE, ACT_NONE, ACT_BEAM,
      ACT_DOOR_UP, ACT_NONE, ACT_NONE, ACT_WINDOW_UP, ACT_WINDOW_DOWN, ACT_DOOR_DOWN},
    '{ACT_HALL, ACT_BEAM, ACT_KITCHEN, ACT_KITCHEN_WORK, ACT_NONE, ACT_NONE,
      ACT_STONE, ACT_NONE, ACT_NONE, ACT_ALL, ACT_CHAND, ACT_ALL},
    '{ACT_HALL, ACT_BEAM, ACT_KITCHEN_WORK, ACT_KITCHEN, ACT_NONE, ACT_NONE,
      ACT_STONE, ACT_NONE, ACT_NONE, ACT_ALL, ACT_ALL, ACT_CHAND}
  };

  // Shadow registers and decoder state
  logic [15:0] hold_limit_ms;
  logic [7:0]  high_limit;
  logic [7:0]  low_limit;
  logic [11:0] stored_masks [NBOARDS];
  logic [31:0] touch_start;
  logic        touch_held;
  logic        dimming;
  logic        dim_upward;

  action_rec_t expected_actions [$];

  task automatic push_action(input logic [3:0] act, input logic up);
    expected_actions.push_back('{act, up, 1'b0});
  endtask

  // Shared chandelier press timer
  task automatic chandelier_event(input logic pressed, input logic [31:0] now,
                                  input logic [7:0] bright);
    logic [31:0] held_ms;
    if (pressed) begin
      if (!touch_held) begin
        touch_start = now;
        touch_held  = 1'b1;
        dimming     = 1'b0;
      end
      held_ms = now - touch_start;
      if (held_ms > {16'd0, hold_limit_ms} && !dimming) begin
        dimming = 1'b1;
        // high limit checked first, so it wins when the limits overlap
        if (bright >= high_limit)
          dim_upward = 1'b0;
        else if (bright <= low_limit)
          dim_upward = 1'b1;
        push_action(ACT_DIM, dim_upward);
      end else if (dimming && (held_ms % DIM_PERIOD_MS) < DIM_WINDOW_MS) begin
        push_action(ACT_DIM, dim_upward);
      end
    end else if (touch_held) begin
      held_ms = now - touch_start;
      if (!dimming && held_ms < {16'd0, hold_limit_ms})
        push_action(ACT_TOGGLE, 1'b0);
      touch_held = 1'b0;
      dimming    = 1'b0;
    end
  endtask

  // Expected actions of one accepted sample, ascending electrode order
  task automatic decode_sample(input logic [1:0] board, input logic [11:0] mask,
                               input logic [31:0] now, input logic [7:0] bright);
    logic [11:0] changed;
    int          first;
    int          e;
    if (board >= NBOARDS)
      return;
    first   = expected_actions.size();
    changed = mask ^ stored_masks[board];
    for (e = 0; e < NPADS; e++) begin
      if (changed[e]) begin
        if (PADS[board][e] == ACT_CHAND)
          chandelier_event(mask[e], now, bright);
        else if (mask[e] && PADS[board][e] != ACT_NONE)
          push_action(PADS[board][e], 1'b0);
      end
    end
    stored_masks[board] = mask;
    if (expected_actions.size() > first)
      expected_actions[expected_actions.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    action_rec_t want;
    if (!rst_n) begin
      hold_limit_ms   = LONG_PRESS_RST;
      high_limit      = BRIGHT_HIGH_RST;
      low_limit       = BRIGHT_LOW_RST;
      for (int b = 0; b < NBOARDS; b++)
        stored_masks[b] = '0;
      touch_start     = '0;
      touch_held      = 1'b0;
      dimming         = 1'b0;
      dim_upward      = 1'b0;
      expected_actions.delete();
      mismatches      = 0;
      actions_checked = 0;
      dims_checked    = 0;
      toggles_checked = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_LONG_PRESS:  hold_limit_ms = cfg_wdata;
          CFG_BRIGHT_HIGH: high_limit    = cfg_wdata[7:0];
          CFG_BRIGHT_LOW:  low_limit     = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_actions.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected action, expected none, got action %0d dim_up %0b last %0b",
                   $time, out_action, out_dim_up, out_last);
        end else begin
          want = expected_actions.pop_front();
          if (out_action !== want.action) begin
            mismatches++;
            $display("%0t: action mismatch, expected %0d, got %0d",
                     $time, want.action, out_action);
          end
          if (out_dim_up !== want.dim_up) begin
            mismatches++;
            $display("%0t: dim_up mismatch, expected %0b, got %0b",
                     $time, want.dim_up, out_dim_up);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, want.last, out_last);
          end
          actions_checked++;
          if (want.action == ACT_DIM)
            dims_checked++;
          if (want.action == ACT_TOGGLE)
            toggles_checked++;
        end
      end
      // sample transfer
      if (in_valid && !in_stall)
        decode_sample(in_board, in_touch_mask, in_now_ms, in_brightness);
    end
    outstanding <= expected_actions.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the touch panel event decoder: stimulus, output stalls and verdict
module tb;
  import tped_pkg::*;

  localparam int NBOARDS      = BOARD_COUNT_DEF;
  localparam int PHASE_ITEMS  = 74;
  localparam int QUIET_CYCLES = 12;
  localparam int NPHASES      = 6;

  // Chandelier electrode on each board
  localparam int CHAND_PAD [NBOARDS] = '{2, 10, 11};

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = CFG_LONG_PRESS;
  logic [15:0] cfg_wdata     = '0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  in_board      = '0;
  logic [11:0] in_touch_mask = '0;
  logic [31:0] in_now_ms     = '0;
  logic [7:0]  in_brightness = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [3:0]  out_action;
  logic        out_dim_up;
  logic        out_last;

  int mismatches;
  int outstanding;
  int actions_checked;
  int dims_checked;
  int toggles_checked;

  // Stimulus bookkeeping
  logic        steady = 1'b0;
  int          stall_left;
  int          sample_count;
  logic [31:0] clock_ms;
  logic [11:0] touch_state [NBOARDS];
  logic [15:0] cur_lp = LONG_PRESS_RST;
  logic [7:0]  cur_hi = BRIGHT_HIGH_RST;
  logic [7:0]  cur_lo = BRIGHT_LOW_RST;

  touch_panel_event_decoder_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_board      (in_board),
    .in_touch_mask (in_touch_mask),
    .in_now_ms     (in_now_ms),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_dim_up    (out_dim_up),
    .out_last      (out_last)
  );

  tped_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_board        (in_board),
    .in_touch_mask   (in_touch_mask),
    .in_now_ms       (in_now_ms),
    .in_brightness   (in_brightness),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_dim_up      (out_dim_up),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .actions_checked (actions_checked),
    .dims_checked    (dims_checked),
    .toggles_checked (toggles_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall after each transfer, sometimes while idle too
  always @(posedge clk) begin : rx_stall
    int k;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (out_valid || $urandom_range(0, 3) == 0) begin
      k = steady ? 0 : $urandom_range(0, 8);
      out_stall  <= (k != 0);
      stall_left <= k;
    end
  end

  // One sample transfer, with a random gap in front
  task automatic send_sample(input logic [1:0] b, input logic [11:0] m,
                             input logic [31:0] t, input logic [7:0] br);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_board      <= b;
    in_touch_mask <= m;
    in_now_ms     <= t;
    in_brightness <= br;
    do @(posedge clk); while (in_stall);
    if (b < NBOARDS) begin
      touch_state[b] = m;
      sample_count++;
    end
  endtask

  // Stop sending and let every expected action come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] lp, input logic [7:0] hi,
                            input logic [7:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_index <= CFG_BRIGHT_HIGH;
    cfg_wdata <= {8'($urandom), hi};
    @(posedge clk);
    cfg_index <= CFG_BRIGHT_LOW;
    cfg_wdata <= {8'($urandom), lo};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lp = lp;
    cur_hi = hi;
    cur_lo = lo;
  endtask

  // Hold durations clustered around the long-press boundary
  function automatic logic [31:0] hold_time();
    case ($urandom_range(0, 5))
      0: return cur_lp - 1;
      1: return cur_lp;
      2: return cur_lp + 1;
      3: return $urandom_range(0, cur_lp);
      4: return cur_lp + $urandom_range(2, 2000);
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  // Brightness near the dim-direction thresholds
  function automatic logic [7:0] pick_bright();
    case ($urandom_range(0, 6))
      0: return cur_hi;
      1: return cur_hi - 8'd1;
      2: return cur_lo;
      3: return cur_lo + 8'd1;
      4: return 8'd0;
      5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic chand_touch(input int b, input logic pressed, input logic [31:0] t);
    logic [11:0] m;
    m = ($urandom_range(0, 1) != 0) ? touch_state[b] : 12'($urandom);
    m[CHAND_PAD[b]] = pressed;
    send_sample(2'(b), m, t, pick_bright());
  endtask

  // Chandelier gesture: up to three boards pressed in turn on the shared timer, some released
  task automatic chand_gesture();
    int          order [NBOARDS];
    int          presses;
    int          j;
    int          k;
    int          tmp;
    logic [31:0] t0;
    logic [31:0] dt;
    logic [31:0] rel;
    order = '{0, 1, 2};
    for (k = NBOARDS - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    if ($urandom_range(0, 7) == 0)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    // clear leftover chandelier touches so every press registers
    for (k = 0; k < NBOARDS; k++)
      if (touch_state[k][CHAND_PAD[k]])
        chand_touch(k, 1'b0, clock_ms);
    t0      = clock_ms + 1;
    presses = $urandom_range(1, NBOARDS);
    dt      = 0;
    for (k = 0; k < presses; k++) begin
      if (k == 1)
        dt = hold_time();
      else if (k == 2)
        dt = ((dt / 300) + $urandom_range(1, 3)) * 300 + $urandom_range(0, 99);
      chand_touch(order[k], 1'b1, t0 + dt);
    end
    rel = (presses == 1) ? hold_time() : dt + $urandom_range(0, 400);
    for (k = 0; k < presses; k++)
      if (k == 0 || $urandom_range(0, 1) != 0)
        chand_touch(order[k], 1'b0, t0 + rel + k);
    clock_ms = t0 + rel + $urandom_range(10, 500);
  endtask

  task automatic noise();
    if ($urandom_range(0, 15) == 0)
      clock_ms = $urandom;
    else
      clock_ms += $urandom_range(0, 3000);
    send_sample(2'($urandom_range(0, 3)), 12'($urandom), clock_ms, 8'($urandom));
  endtask

  initial begin : stimulus
    int          phase;
    int          phase_start;
    logic        paused;
    logic [15:0] lp;
    logic [7:0]  hi;
    logic [7:0]  lo;
    sample_count = 0;
    paused       = 1'b0;
    clock_ms     = 32'd20000;
    for (int b = 0; b < NBOARDS; b++)
      touch_state[b] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all pads, long press with repeat dim, exact hold, wrap, ignored board
    send_sample(2'd0, 12'hFFF, 32'd1000, 8'd0);
    send_sample(2'd1, 12'hFFF, 32'd1801, 8'd255);
    send_sample(2'd2, 12'hFFF, 32'd1900, 8'd128);
    send_sample(2'd0, 12'h000, 32'd2000, 8'd0);
    send_sample(2'd1, 12'h000, 32'd2100, 8'd0);
    send_sample(2'd2, 12'h000, 32'd2100, 8'd0);
    send_sample(2'd0, 12'h004, 32'd5000, 8'd0);
    send_sample(2'd0, 12'h000, 32'd5800, 8'd0);
    send_sample(2'd1, 12'h400, 32'd6000, 8'd0);
    send_sample(2'd2, 12'h800, 32'd6801, 8'd0);
    send_sample(2'd1, 12'h000, 32'd6850, 8'd0);
    send_sample(2'd2, 12'h000, 32'd6900, 8'd0);
    send_sample(2'd2, 12'h800, 32'hFFFF_FFFF, 8'd77);
    send_sample(2'd2, 12'h000, 32'h0000_0010, 8'd77);
    send_sample(2'd3, 12'hFFF, 32'd123, 8'd255);
    send_sample(2'd3, 12'h000, 32'd124, 8'd0);
    send_sample(2'd0, 12'h004, 32'd10000, 8'd100);
    send_sample(2'd1, 12'h400, 32'd10801, 8'd100);
    send_sample(2'd2, 12'h800, 32'd11150, 8'd100);
    send_sample(2'd0, 12'h000, 32'd11200, 8'd100);
    send_sample(2'd1, 12'h000, 32'd11200, 8'd100);
    send_sample(2'd2, 12'h000, 32'd11200, 8'd100);
    drain();

    // Random phases, each under its own register setting
    for (phase = 0; phase < NPHASES; phase++) begin
      steady = (phase == 3);
      case (phase)
        1: write_regs(16'd1, 8'd0, 8'd255);
        2: write_regs(16'hFFFF, 8'd255, 8'd0);
        3: write_regs(16'd300, 8'd10, 8'd200);
        default: begin
          lp = 16'($urandom_range(1, 2000));
          hi = 8'($urandom);
          lo = 8'($urandom);
          if (phase != 0)
            write_regs(lp, hi, lo);
        end
      endcase
      phase_start = sample_count;
      while (sample_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7)
          chand_gesture();
        else
          noise();
        // one mid-phase pause until all results are out
        if (phase == 1 && !paused && sample_count - phase_start > 30) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    $display("Sent %0d touch samples over %0d register settings;", sample_count, NPHASES);
    $display("checked %0d actions, %0d of them dims and %0d toggles.",
             actions_checked, dims_checked, toggles_checked);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d actions still expected", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
